@@ rtl/ticket_ordered_resource_grant_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ticket-ordered resource grant block
// Shared assertion forms, clocked on clock and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TICKET_ORDERED_RESOURCE_GRANT_TOP_DEFINES_SVH
`define TICKET_ORDERED_RESOURCE_GRANT_TOP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define TORG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define TORG_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

@@ rtl/torg_pkg.sv @@
// ----------------------------------------------------------------------------
// Ticket-ordered resource grant package
// Operation and status codes plus the command and status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package torg_pkg;

   // Request operations.
   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_JOIN   = 3'd2;
   localparam logic [2:0] OP_LEAVE  = 3'd3;
   localparam logic [2:0] OP_WAIT   = 3'd4;
   localparam logic [2:0] OP_ARB    = 3'd5;
   localparam logic [2:0] OP_CLEAR  = 3'd6;

   // Result status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DUP     = 2'd1;
   localparam logic [1:0] ST_NOSUCH  = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic key_rd;
      logic key_latch;
      logic scan_rd;
      logic drop_cmp;
      logic min_cmp;
      logic arb_start;
      logic grant;
      logic r_inc;
      logic emit;
      logic emit_grant;
      logic emit_last;
   } torg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] op;
      logic       go;
      logic       has_ticket;
      logic       q_last;
      logic       r_last;
      logic       live;
      logic       grant_ok;
      logic       out_free;
   } torg_stat_type;

endpackage

@@ rtl/torg_if.sv @@
// ----------------------------------------------------------------------------
// Ticket-ordered resource grant channel interfaces
// Valid/ready channels for requests and for results.
// ----------------------------------------------------------------------------
interface torg_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [2:0] resource_id;
   logic [3:0] requester_id;

   modport source (output valid, req_type, resource_id, requester_id, input ready);
   modport sink (input valid, req_type, resource_id, requester_id, output ready);
endinterface

interface torg_rsp_if #(parameter int TICKET_WIDTH = 32);
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic                    grant_valid;
   logic [2:0]              grant_resource;
   logic [3:0]              grant_requester;
   logic [TICKET_WIDTH-1:0] assigned_ticket;
   logic                    idle;
   logic                    last;

   modport source (output valid, status, grant_valid, grant_resource, grant_requester,
                   assigned_ticket, idle, last, input ready);
   modport sink (input valid, status, grant_valid, grant_resource, grant_requester,
                 assigned_ticket, idle, last, output ready);
endinterface

@@ rtl/torg_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module torg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read before write on the same address, read data registered.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/torg_ctrl.sv @@
// ----------------------------------------------------------------------------
// Ticket-ordered resource grant controller
// Sequences each request: execute, ticket scans, arbitration and results.
// ----------------------------------------------------------------------------
module torg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  torg_pkg::torg_stat_type stat,
   output torg_pkg::torg_cmd_type  cmd
);
   import torg_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_EXEC      = 4'd1;
   localparam logic [3:0] S_KEY_RD    = 4'd2;
   localparam logic [3:0] S_KEY_LATCH = 4'd3;
   localparam logic [3:0] S_DROP_RD   = 4'd4;
   localparam logic [3:0] S_DROP_CMP  = 4'd5;
   localparam logic [3:0] S_ARB_RES   = 4'd6;
   localparam logic [3:0] S_MIN_RD    = 4'd7;
   localparam logic [3:0] S_MIN_CMP   = 4'd8;
   localparam logic [3:0] S_ARB_CHK   = 4'd9;
   localparam logic [3:0] S_EMIT_GNT  = 4'd10;
   localparam logic [3:0] S_ARB_NEXT  = 4'd11;
   localparam logic [3:0] S_EMIT      = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.op == OP_JOIN && stat.go) begin
               state_in = stat.has_ticket ? S_KEY_RD : S_DROP_RD;
            end else if (stat.op == OP_LEAVE && stat.go && stat.has_ticket) begin
               state_in = S_KEY_RD;
            end else if (stat.op == OP_ARB) begin
               state_in = S_ARB_RES;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_KEY_RD: begin
            cmd.key_rd = 1'b1;
            state_in   = S_KEY_LATCH;
         end
         S_KEY_LATCH: begin
            cmd.key_latch = 1'b1;
            state_in      = S_DROP_RD;
         end
         S_DROP_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_DROP_CMP;
         end
         S_DROP_CMP: begin
            cmd.drop_cmp = 1'b1;
            state_in     = stat.q_last ? S_EMIT : S_DROP_RD;
         end
         S_ARB_RES: begin
            cmd.arb_start = 1'b1;
            state_in      = stat.live ? S_MIN_RD : S_ARB_NEXT;
         end
         S_MIN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_MIN_CMP;
         end
         S_MIN_CMP: begin
            cmd.min_cmp = 1'b1;
            state_in    = stat.q_last ? S_ARB_CHK : S_MIN_RD;
         end
         S_ARB_CHK: begin
            if (stat.grant_ok) begin
               cmd.grant = 1'b1;
               state_in  = S_EMIT_GNT;
            end else begin
               state_in = S_ARB_NEXT;
            end
         end
         S_EMIT_GNT: begin
            if (stat.out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_grant = 1'b1;
               state_in       = S_ARB_NEXT;
            end
         end
         S_ARB_NEXT: begin
            if (stat.r_last) begin
               state_in = S_EMIT;
            end else begin
               cmd.r_inc = 1'b1;
               state_in  = S_ARB_RES;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/torg_dp.sv @@
// ----------------------------------------------------------------------------
// Ticket-ordered resource grant datapath
// Holds tickets, resource flags, member and waiting rows, the scan
// registers and the result register.
// ----------------------------------------------------------------------------
module torg_dp #(
   parameter int NUM_RESOURCES  = 8,
   parameter int NUM_REQUESTERS = 16,
   parameter int TICKET_WIDTH   = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  torg_pkg::torg_cmd_type  cmd,
   output torg_pkg::torg_stat_type stat,
   input  logic [2:0]              req_type,
   input  logic [2:0]              resource_id,
   input  logic [3:0]              requester_id,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic                    rsp_grant_valid,
   output logic [2:0]              rsp_grant_resource,
   output logic [3:0]              rsp_grant_requester,
   output logic [TICKET_WIDTH-1:0] rsp_assigned_ticket,
   output logic                    rsp_idle,
   output logic                    rsp_last
);
   import torg_pkg::*;

   localparam int RW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
   localparam int QW = $clog2(NUM_REQUESTERS);

   // Captured request.
   logic [2:0] op_ff;
   logic [2:0] res_ff;
   logic [3:0] rq_ff;

   // Block state.
   logic [TICKET_WIDTH-1:0]   counter_ff;
   logic [NUM_REQUESTERS-1:0] has_tk_ff;
   logic [NUM_RESOURCES-1:0]  active_ff;
   logic [NUM_REQUESTERS-1:0] member_ff [NUM_RESOURCES];
   logic [NUM_REQUESTERS-1:0] waiting_ff [NUM_RESOURCES];

   // Scan registers.
   logic [TICKET_WIDTH-1:0] key_ff;
   logic [QW-1:0]           q_ff;
   logic [RW-1:0]           r_ff;
   logic [QW-1:0]           best_ff;
   logic [TICKET_WIDTH-1:0] best_tk_ff;
   logic                    best_v_ff;
   logic [1:0]              st_ff;

   // Result register.
   logic                    out_v_ff;
   logic [1:0]              out_st_ff;
   logic                    out_gv_ff;
   logic [2:0]              out_gr_ff;
   logic [3:0]              out_gq_ff;
   logic [TICKET_WIDTH-1:0] out_tk_ff;
   logic                    out_idle_ff;
   logic                    out_last_ff;

   logic                      res_ok;
   logic                      rq_ok;
   logic [RW-1:0]             ridx;
   logic [QW-1:0]             qidx;
   logic                      act;
   logic                      go;
   logic                      q_last;
   logic                      r_last;
   logic                      ram_we;
   logic [QW-1:0]             ram_raddr;
   logic [TICKET_WIDTH-1:0]   ram_rdata;
   logic [TICKET_WIDTH-1:0]   next_tk;
   logic                      drop_hit;
   logic                      min_hit;
   logic                      all_idle;
   logic [NUM_REQUESTERS-1:0] drop_mask;
   logic [NUM_REQUESTERS-1:0] join_mask;

   // Request decode against the configured sizes.
   assign res_ok  = {5'd0, res_ff} < 8'(NUM_RESOURCES);
   assign rq_ok   = {4'd0, rq_ff} < 8'(NUM_REQUESTERS);
   assign ridx    = RW'(8'(res_ff));
   assign qidx    = QW'(8'(rq_ff));
   assign act     = res_ok && active_ff[ridx];
   assign go      = act && rq_ok;
   assign q_last  = q_ff == QW'(NUM_REQUESTERS - 1);
   assign r_last  = r_ff == RW'(NUM_RESOURCES - 1);
   assign next_tk = counter_ff + TICKET_WIDTH'(1);

   // A new ticket is drawn on the first join of a requester.
   assign ram_we    = cmd.exec && op_ff == OP_JOIN && go && !has_tk_ff[qidx];
   assign ram_raddr = cmd.key_rd ? qidx : q_ff;

   torg_ram #(
      .WIDTH (TICKET_WIDTH),
      .DEPTH (NUM_REQUESTERS)
   ) u_ticket_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (qidx),
      .wdata (next_tk),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Scan compares.
   assign drop_hit = member_ff[ridx][q_ff] && has_tk_ff[q_ff] && ram_rdata == key_ff;
   assign min_hit  = member_ff[r_ff][q_ff] && (!best_v_ff || ram_rdata < best_tk_ff);

   // Row masks for the final step of a join scan.
   assign drop_mask = drop_hit ? (NUM_REQUESTERS'(1) << q_ff) : '0;
   assign join_mask = NUM_REQUESTERS'(1) << qidx;

   // Idle flag over all member and waiting rows.
   always_comb begin
      all_idle = 1'b1;
      for (int r = 0; r < NUM_RESOURCES; r++) begin
         if (member_ff[r] != '0 || waiting_ff[r] != '0) begin
            all_idle = 1'b0;
         end
      end
   end

   // Status to the controller.
   always_comb begin
      stat.op         = op_ff;
      stat.go         = go;
      stat.has_ticket = has_tk_ff[qidx];
      stat.q_last     = q_last;
      stat.r_last     = r_last;
      stat.live       = active_ff[r_ff] && member_ff[r_ff] != '0;
      stat.grant_ok   = waiting_ff[r_ff][best_ff];
      stat.out_free   = !out_v_ff || rsp_ready;
   end

   // Control state: tickets held, resource flags, rows and counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         has_tk_ff  <= '0;
         active_ff  <= '0;
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            member_ff[r]  <= '0;
            waiting_ff[r] <= '0;
         end
      end else begin
         if (cmd.exec) begin
            case (op_ff)
               OP_ADD: begin
                  if (res_ok && !act) begin
                     active_ff[ridx]  <= 1'b1;
                     member_ff[ridx]  <= '0;
                     waiting_ff[ridx] <= '0;
                  end
               end
               OP_REMOVE: begin
                  if (act) begin
                     active_ff[ridx]  <= 1'b0;
                     member_ff[ridx]  <= '0;
                     waiting_ff[ridx] <= '0;
                  end
               end
               OP_JOIN: begin
                  if (ram_we) begin
                     counter_ff      <= next_tk;
                     has_tk_ff[qidx] <= 1'b1;
                  end
               end
               OP_LEAVE: begin
                  if (go) begin
                     waiting_ff[ridx][qidx] <= 1'b0;
                  end
               end
               OP_WAIT: begin
                  if (go) begin
                     waiting_ff[ridx][qidx] <= 1'b1;
                  end
               end
               OP_CLEAR: begin
                  counter_ff <= '0;
                  for (int r = 0; r < NUM_RESOURCES; r++) begin
                     member_ff[r]  <= '0;
                     waiting_ff[r] <= '0;
                  end
               end
               default: begin
               end
            endcase
         end
         // Drop members sharing the key; a join then takes its own place.
         if (cmd.drop_cmp) begin
            if (q_last && op_ff == OP_JOIN) begin
               member_ff[ridx] <= (member_ff[ridx] & ~drop_mask) | join_mask;
            end else if (drop_hit) begin
               member_ff[ridx][q_ff] <= 1'b0;
            end
         end
         if (cmd.grant) begin
            waiting_ff[r_ff][best_ff] <= 1'b0;
         end
      end
   end

   // Request capture and scan registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_type;
         res_ff <= resource_id;
         rq_ff  <= requester_id;
      end
      if (cmd.exec) begin
         q_ff <= '0;
         r_ff <= '0;
         key_ff <= next_tk;
         case (op_ff)
            OP_ADD:    st_ff <= !res_ok ? ST_IGNORED : (act ? ST_DUP : ST_OK);
            OP_REMOVE: st_ff <= act ? ST_OK : ST_NOSUCH;
            OP_JOIN, OP_LEAVE, OP_WAIT: st_ff <= go ? ST_OK : ST_IGNORED;
            default:   st_ff <= ST_OK;
         endcase
      end
      if (cmd.key_latch) begin
         key_ff <= ram_rdata;
      end
      if (cmd.drop_cmp) begin
         q_ff <= q_ff + QW'(1);
      end
      if (cmd.arb_start) begin
         q_ff      <= '0;
         best_v_ff <= 1'b0;
      end
      if (cmd.min_cmp) begin
         q_ff <= q_ff + QW'(1);
         if (min_hit) begin
            best_ff    <= q_ff;
            best_tk_ff <= ram_rdata;
            best_v_ff  <= 1'b1;
         end
      end
      if (cmd.r_inc) begin
         r_ff <= r_ff + RW'(1);
      end
   end

   // Result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_v_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_v_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_st_ff   <= cmd.emit_grant ? ST_OK : st_ff;
         out_gv_ff   <= cmd.emit_grant;
         out_gr_ff   <= cmd.emit_grant ? 3'(8'(r_ff)) : 3'd0;
         out_gq_ff   <= cmd.emit_grant ? 4'(8'(best_ff)) : 4'd0;
         out_tk_ff   <= (!cmd.emit_grant && op_ff == OP_JOIN && st_ff == ST_OK)
                        ? key_ff : '0;
         out_idle_ff <= all_idle;
         out_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_status          = out_st_ff;
   assign rsp_grant_valid     = out_gv_ff;
   assign rsp_grant_resource  = out_gr_ff;
   assign rsp_grant_requester = out_gq_ff;
   assign rsp_assigned_ticket = out_tk_ff;
   assign rsp_idle            = out_idle_ff;
   assign rsp_last            = out_last_ff;

endmodule

@@ rtl/ticket_ordered_resource_grant_top.sv @@
// Add, remove, wait, clear and leave without a ticket go from execute straight to the result.
// A first join scans the ticket RAM once per requester; a join or leave with a ticket held
// first reads and latches its own ticket as the key, then runs the same scan.
// Arbitrate runs a minimum-ticket scan over each live resource, then a grant check; result stalls hold it.
// One request at a time: the next transfer can come in the cycle after the closing result is loaded.
// Reset (synchronous, active high) clears counter, tickets held, resources and rows.
// ----------------------------------------------------------------------------
// Ticket-ordered resource grant top level
// Grants shared resources strictly in ticket order through a controller
// and datapath pair.
// ----------------------------------------------------------------------------
`include "ticket_ordered_resource_grant_top_defines.svh"

module ticket_ordered_resource_grant_top #(
   parameter int NUM_RESOURCES  = 8,
   parameter int NUM_REQUESTERS = 16,
   parameter int TICKET_WIDTH   = 32
) (
   input logic  clock,
   input logic  reset,
   torg_req_if.sink   req_ch,
   torg_rsp_if.source rsp_ch
);
   import torg_pkg::*;

   torg_cmd_type  cmd;
   torg_stat_type stat;

   // Sequencer.
   torg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and compare logic.
   torg_dp #(
      .NUM_RESOURCES  (NUM_RESOURCES),
      .NUM_REQUESTERS (NUM_REQUESTERS),
      .TICKET_WIDTH   (TICKET_WIDTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_type            (req_ch.req_type),
      .resource_id         (req_ch.resource_id),
      .requester_id        (req_ch.requester_id),
      .rsp_ready           (rsp_ch.ready),
      .rsp_valid           (rsp_ch.valid),
      .rsp_status          (rsp_ch.status),
      .rsp_grant_valid     (rsp_ch.grant_valid),
      .rsp_grant_resource  (rsp_ch.grant_resource),
      .rsp_grant_requester (rsp_ch.grant_requester),
      .rsp_assigned_ticket (rsp_ch.assigned_ticket),
      .rsp_idle            (rsp_ch.idle),
      .rsp_last            (rsp_ch.last)
   );

   // A grant is never the closing result of an arbitration.
   `TORG_NEVER(a_grant_not_last, rsp_ch.valid && rsp_ch.grant_valid && rsp_ch.last, "grant last")
   // A grant always carries ok status.
   `TORG_NEVER(a_grant_ok, rsp_ch.valid && rsp_ch.grant_valid && rsp_ch.status != ST_OK, "bad st")
   // Only one request is in work at a time.
   `TORG_ASSERT(a_one_item, req_ch.valid && req_ch.ready |=> !req_ch.ready, "taken while busy")

endmodule
